>>> sv/assert_macros.svh
// Assertion macros shared by the list engine RTL.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// Check an implication whose consequent must hold in the following cycle.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

>>> sv/slte_pkg.sv
// Package for the list table engine: opcodes, status codes, sequencer states.
// Depends on nothing.
`default_nettype none
package slte_pkg;
   localparam int LIST_CAPACITY_DEF = 64;
   localparam int ELEM_BITS_DEF     = 32;

   typedef enum logic [2:0] {
      OP_CLEAR, OP_INSERT, OP_APPEND, OP_DELETE, OP_DELETE_LAST,
      OP_FIND, OP_EXTREMES, OP_SORT
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK, ST_FULL, ST_EMPTY, ST_RANGE, ST_NOT_FOUND
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_UP_RD, S_UP_WR, S_DN_RD, S_DN_WR, S_PUT,
      S_SCAN_RD, S_SCAN_CHK, S_SRT_RD, S_SRT_CMP, S_SRT_RDJ, S_SRT_CHK,
      S_DONE
   } state_type;
endpackage
`default_nettype wire

>>> sv/slte_ram.sv
// Generic single-port RAM with registered read.
// Depends on nothing.
`default_nettype none
module slte_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

>>> sv/static_list_table_engine_core.sv
// Top level of the list table engine: sequencer, shared comparator, list RAM.
// Depends on slte_pkg, slte_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
// Ordered list of signed words in one single-port RAM, driven by one command
// word at a time. Pulse start while busy is low; busy stays high until the
// result word appears on the rsp_ ports with rsp_valid for exactly one cycle,
// which the receiver must take then, since it cannot stall. Insert and delete
// move the tail through the RAM port one element at a time, a read and then a
// write per element moved. Find and extremes read one element at a time, each
// read followed by a check. Sort is insertion sort on the single RAM port, so
// O(count^2) compares and moves in the worst case; the one RAM port paces
// every command.
module static_list_table_engine_core
   import slte_pkg::*;
#(
   parameter int LIST_CAPACITY = LIST_CAPACITY_DEF,
   parameter int ELEM_BITS     = ELEM_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [2:0]         req_opcode,
   input  wire logic signed [31:0] req_item_value,
   input  wire logic [6:0]         req_position,
   input  wire logic               req_ascending,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_out_value,
   output logic signed [31:0]      rsp_out_min,
   output logic signed [6:0]       rsp_found_index,
   output logic [2:0]              rsp_status,
   output logic [6:0]              rsp_list_length
);
   localparam int AW = $clog2(LIST_CAPACITY);
   localparam int CW = $clog2(LIST_CAPACITY + 1);
   localparam int CAP = LIST_CAPACITY;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in;
   logic [2:0] op_ff, op_in;
   logic [ELEM_BITS-1:0] val_ff, val_in, key_ff, key_in;
   logic [ELEM_BITS-1:0] max_ff, max_in, min_ff, min_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic asc_ff, asc_in;
   logic [2:0] st_ff, st_in;
   logic [6:0] fidx_ff, fidx_in;
   logic first_ff, first_in;

   logic we;
   logic [AW-1:0] addr;
   logic [ELEM_BITS-1:0] wdata, rdata;

   slte_ram #(.WIDTH(ELEM_BITS), .DEPTH(LIST_CAPACITY)) u_ram (
      .clock(clock), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));

   // shared signed comparator: a < b
   logic [ELEM_BITS-1:0] cmp_a, cmp_b;
   logic cmp_lt;
   assign cmp_lt = $signed(cmp_a) < $signed(cmp_b);

   function automatic logic [31:0] ext32(input logic [ELEM_BITS-1:0] x);
      logic [63:0] w;
      w = 64'($signed(x));
      return w[31:0];
   endfunction

   logic [63:0] item_ext;
   assign item_ext = 64'(req_item_value);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      i_ff <= i_in; j_ff <= j_in; op_ff <= op_in; val_ff <= val_in;
      key_ff <= key_in; max_ff <= max_in; min_ff <= min_in; pos_ff <= pos_in;
      asc_ff <= asc_in; st_ff <= st_in; fidx_ff <= fidx_in; first_ff <= first_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (start) begin
            unique case (opcode_type'(req_opcode))
               OP_CLEAR, OP_APPEND:
                  state_in = (opcode_type'(req_opcode) == OP_APPEND
                              && count_ff != CW'(CAP)) ? S_PUT : S_DONE;
               OP_INSERT:
                  state_in = (count_ff == CW'(CAP) || 32'(req_position) > 32'(count_ff))
                             ? S_DONE : ((32'(req_position) == 32'(count_ff)) ? S_PUT
                             : S_UP_RD);
               OP_DELETE:
                  state_in = (count_ff == '0 || 32'(req_position) >= 32'(count_ff))
                             ? S_DONE : S_DN_RD;
               OP_DELETE_LAST, OP_FIND, OP_EXTREMES:
                  state_in = (count_ff == '0) ? S_DONE : S_SCAN_RD;
               OP_SORT: state_in = (count_ff > CW'(1)) ? S_SRT_RD : S_DONE;
               default: state_in = S_DONE;
            endcase
         end
         S_UP_RD:    state_in = S_UP_WR;
         S_UP_WR:    state_in = (i_ff - CW'(1) == pos_ff) ? S_PUT : S_UP_RD;
         S_DN_RD:    state_in = S_DN_WR;
         S_DN_WR:    state_in = (i_ff + CW'(2) >= count_ff) ? S_DONE : S_DN_RD;
         S_PUT:      state_in = S_DONE;
         S_SCAN_RD:  state_in = S_SCAN_CHK;
         S_SCAN_CHK: begin
            if (op_ff == OP_DELETE_LAST) state_in = S_DONE;
            else if (op_ff == OP_FIND && rdata == val_ff) state_in = S_DONE;
            else state_in = (i_ff + CW'(1) >= count_ff) ? S_DONE : S_SCAN_RD;
         end
         S_SRT_RD:   state_in = S_SRT_CMP;
         S_SRT_CMP:  state_in = S_SRT_RDJ;
         S_SRT_RDJ:  state_in = S_SRT_CHK;
         S_SRT_CHK: begin
            if (cmp_lt && j_ff != '0) state_in = S_SRT_RDJ;
            else state_in = (i_ff + CW'(1) >= count_ff) ? S_DONE : S_SRT_RD;
         end
         S_DONE:     state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      count_in = count_ff; i_in = i_ff; j_in = j_ff; op_in = op_ff;
      val_in = val_ff; key_in = key_ff; max_in = max_ff; min_in = min_ff;
      pos_in = pos_ff; asc_in = asc_ff; st_in = st_ff; fidx_in = fidx_ff;
      first_in = first_ff;
      we = 1'b0; addr = '0; wdata = '0;
      cmp_a = rdata; cmp_b = key_ff;
      unique case (state_ff)
         S_IDLE: if (start) begin
            op_in = req_opcode; val_in = item_ext[ELEM_BITS-1:0];
            pos_in = CW'(req_position); asc_in = req_ascending;
            st_in = ST_OK; fidx_in = 7'h7F; first_in = 1'b1;
            max_in = '0; min_in = '0;
            unique case (opcode_type'(req_opcode))
               OP_CLEAR: count_in = '0;
               OP_INSERT: begin
                  if (count_ff == CW'(CAP)) st_in = ST_FULL;
                  else if (32'(req_position) > 32'(count_ff)) st_in = ST_RANGE;
                  i_in = count_ff;
                  pos_in = (32'(req_position) == 32'(count_ff)) ? count_ff
                           : CW'(req_position);
               end
               OP_APPEND: begin
                  if (count_ff == CW'(CAP)) st_in = ST_FULL;
                  pos_in = count_ff;
               end
               OP_DELETE: begin
                  if (count_ff == '0) st_in = ST_EMPTY;
                  else if (32'(req_position) >= 32'(count_ff)) st_in = ST_RANGE;
                  i_in = CW'(req_position);
                  // fetch the element being removed
                  addr = AW'(req_position);
               end
               OP_DELETE_LAST: begin
                  if (count_ff == '0) st_in = ST_EMPTY;
                  i_in = count_ff - CW'(1);
               end
               OP_FIND: begin
                  st_in = ST_NOT_FOUND; i_in = '0;
               end
               OP_EXTREMES: begin
                  if (count_ff == '0) st_in = ST_EMPTY;
                  i_in = '0;
               end
               OP_SORT: i_in = CW'(1);
               default: ;
            endcase
         end
         S_UP_RD: addr = AW'(i_ff - CW'(1));
         S_UP_WR: begin
            we = 1'b1; addr = AW'(i_ff); wdata = rdata; i_in = i_ff - CW'(1);
         end
         S_DN_RD: addr = AW'(i_ff + CW'(1));
         S_DN_WR: begin
            we = 1'b1; addr = AW'(i_ff); wdata = rdata; i_in = i_ff + CW'(1);
            // trim the count on the last move
            if (i_ff + CW'(2) >= count_ff) count_in = count_ff - CW'(1);
         end
         S_PUT: begin
            we = 1'b1; addr = AW'(pos_ff); wdata = val_ff;
            count_in = count_ff + CW'(1);
         end
         S_SCAN_RD: addr = AW'(i_ff);
         S_SCAN_CHK: begin
            i_in = i_ff + CW'(1);
            unique case (opcode_type'(op_ff))
               OP_DELETE_LAST: begin
                  max_in = rdata; count_in = count_ff - CW'(1);
               end
               OP_FIND: if (rdata == val_ff) begin
                  st_in = ST_OK; fidx_in = 7'(i_ff);
               end
               default: begin
                  // hold max in max_ff, min in min_ff
                  cmp_a = max_ff; cmp_b = rdata;
                  if (first_ff || cmp_lt) max_in = rdata;
                  if (first_ff || $signed(rdata) < $signed(min_ff)) min_in = rdata;
                  first_in = 1'b0;
               end
            endcase
         end
         S_SRT_RD: addr = AW'(i_ff);
         S_SRT_CMP: begin
            key_in = rdata; j_in = i_ff; addr = AW'(i_ff - CW'(1));
         end
         S_SRT_RDJ: addr = AW'(j_ff - CW'(1));
         S_SRT_CHK: begin
            // rdata holds element j-1; shift it up while key belongs before it
            if (asc_ff) begin cmp_a = key_ff; cmp_b = rdata; end
            else begin cmp_a = rdata; cmp_b = key_ff; end
            we = 1'b1;
            if (cmp_lt && j_ff != '0) begin
               addr = AW'(j_ff); wdata = rdata; j_in = j_ff - CW'(1);
            end else begin
               addr = AW'(j_ff); wdata = key_ff; i_in = i_ff + CW'(1);
            end
         end
         default: ;
      endcase
   end

   // a delete-at reads its element at the start of the shift
   logic [ELEM_BITS-1:0] removed_ff;
   logic grab_ff;
   always_ff @(posedge clock) begin
      grab_ff <= (state_ff == S_IDLE) && start
                 && opcode_type'(req_opcode) == OP_DELETE;
      if (grab_ff) removed_ff <= rdata;
   end

   // outputs
   always_comb begin
      busy = (state_ff != S_IDLE);
      rsp_valid = (state_ff == S_DONE);
      rsp_list_length = 7'(count_ff);
      rsp_status = st_ff;
      rsp_found_index = fidx_ff;
      rsp_out_value = '0; rsp_out_min = '0;
      case (op_ff)
         OP_DELETE: if (st_ff == ST_OK) rsp_out_value = ext32(removed_ff);
         OP_DELETE_LAST: if (st_ff == ST_OK) rsp_out_value = ext32(max_ff);
         OP_EXTREMES: if (st_ff == ST_OK) begin
            rsp_out_value = ext32(max_ff); rsp_out_min = ext32(min_ff);
         end
         default: ;
      endcase
   end

   `ASSERT_IMPLY(a_valid_busy, clock, reset, rsp_valid, busy)
   `ASSERT_NEXT(a_done_idle, clock, reset, rsp_valid, !busy)
   `ASSERT_IMPLY(a_len_cap, clock, reset, 1'b1, 32'(count_ff) <= CAP)
endmodule
`default_nettype wire

>>> verif/list_engine_checker.sv
// Checker for the list table engine: watches command and result words,
// predicts each result from its own copy of the list, and counts mismatches.
// Depends on slte_pkg.
`timescale 1ns / 100ps
module list_engine_checker
   import slte_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               busy,
   input  wire logic [2:0]         req_opcode,
   input  wire logic signed [31:0] req_item_value,
   input  wire logic [6:0]         req_position,
   input  wire logic               req_ascending,
   input  wire logic               rsp_valid,
   input  wire logic signed [31:0] rsp_out_value,
   input  wire logic signed [31:0] rsp_out_min,
   input  wire logic signed [6:0]  rsp_found_index,
   input  wire logic [2:0]         rsp_status,
   input  wire logic [6:0]         rsp_list_length,
   output int                      fail_count,
   output int                      pending_words
);
   localparam int CAP = LIST_CAPACITY_DEF;

   typedef struct packed {
      logic signed [31:0] value;
      logic signed [31:0] min;
      logic signed [6:0]  index;
      status_type         status;
      logic [6:0]         length;
   } list_result_type;

   logic signed [31:0] shadow_list [CAP];
   int                 shadow_count;
   list_result_type    expected_words [$];

   assign pending_words = expected_words.size();

   // Advance the shadow list by one command and return the result it yields.
   function automatic list_result_type apply_command(opcode_type op,
         logic signed [31:0] v, int pos, logic asc);
      list_result_type r;
      logic signed [31:0] key;
      int j;
      r = '{value: 0, min: 0, index: -7'sd1, status: ST_OK, length: 0};
      case (op)
         OP_CLEAR: shadow_count = 0;
         OP_INSERT: begin
            if (shadow_count >= CAP) r.status = ST_FULL;
            else if (pos > shadow_count) r.status = ST_RANGE;
            else begin
               for (int i = shadow_count; i > pos; i--) shadow_list[i] = shadow_list[i-1];
               shadow_list[pos] = v;
               shadow_count++;
            end
         end
         OP_APPEND: begin
            if (shadow_count >= CAP) r.status = ST_FULL;
            else begin
               shadow_list[shadow_count] = v;
               shadow_count++;
            end
         end
         OP_DELETE: begin
            if (shadow_count == 0) r.status = ST_EMPTY;
            else if (pos >= shadow_count) r.status = ST_RANGE;
            else begin
               r.value = shadow_list[pos];
               for (int i = pos; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
               shadow_count--;
            end
         end
         OP_DELETE_LAST: begin
            if (shadow_count == 0) r.status = ST_EMPTY;
            else begin
               shadow_count--;
               r.value = shadow_list[shadow_count];
            end
         end
         OP_FIND: begin
            r.status = ST_NOT_FOUND;
            for (int i = 0; i < shadow_count; i++)
               if (shadow_list[i] == v) begin
                  r.index  = 7'(i);
                  r.status = ST_OK;
                  break;
               end
         end
         OP_EXTREMES: begin
            if (shadow_count == 0) r.status = ST_EMPTY;
            else begin
               r.value = shadow_list[0];
               r.min   = shadow_list[0];
               for (int i = 1; i < shadow_count; i++) begin
                  if (shadow_list[i] > r.value) r.value = shadow_list[i];
                  if (shadow_list[i] < r.min)   r.min   = shadow_list[i];
               end
            end
         end
         default: begin
            for (int i = 1; i < shadow_count; i++) begin
               key = shadow_list[i];
               j = i;
               while (j > 0 && (asc ? key < shadow_list[j-1] : shadow_list[j-1] < key)) begin
                  shadow_list[j] = shadow_list[j-1];
                  j--;
               end
               shadow_list[j] = key;
            end
         end
      endcase
      r.length = 7'(shadow_count);
      return r;
   endfunction

   always @(posedge clock) begin
      list_result_type want;
      if (reset) begin
         shadow_count = 0;
         fail_count   = 0;
         expected_words.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected result word, status %0d", $time, rsp_status);
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_out_value !== want.value) begin
                  $display("%0t: out_value expected %0d actual %0d", $time, want.value,
                     rsp_out_value);
                  fail_count++;
               end
               if (rsp_out_min !== want.min) begin
                  $display("%0t: out_min expected %0d actual %0d", $time, want.min,
                     rsp_out_min);
                  fail_count++;
               end
               if (rsp_found_index !== want.index) begin
                  $display("%0t: found_index expected %0d actual %0d", $time, want.index,
                     rsp_found_index);
                  fail_count++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, want.status,
                     rsp_status);
                  fail_count++;
               end
               if (rsp_list_length !== want.length) begin
                  $display("%0t: list_length expected %0d actual %0d", $time, want.length,
                     rsp_list_length);
                  fail_count++;
               end
            end
         end
         // The result word of this command comes later, so queue after the pop.
         if (start && !busy)
            expected_words.push_back(apply_command(opcode_type'(req_opcode),
               req_item_value, int'(req_position), req_ascending));
      end
   end
endmodule

>>> verif/tb_top.sv
// Testbench top for the list table engine: clock, reset, command stimulus and verdict.
// Depends on slte_pkg, static_list_table_engine_core and list_engine_checker.
`timescale 1ns / 100ps
module tb_top;
   import slte_pkg::*;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [2:0]         req_opcode = OP_CLEAR;
   logic signed [31:0] req_item_value = '0;
   logic [6:0]         req_position = '0;
   logic               req_ascending = 1'b0;
   logic               rsp_valid;
   logic signed [31:0] rsp_out_value, rsp_out_min;
   logic signed [6:0]  rsp_found_index;
   logic [2:0]         rsp_status;
   logic [6:0]         rsp_list_length;
   int                 fail_count, pending_words;
   int                 idle_percent;
   int                 list_size;

   always #5 clock = ~clock;

   static_list_table_engine_core DUT (.*);

   list_engine_checker checker_inst (.*);

   // Pick a word value: mostly from a small pool so finds hit and sorts see
   // duplicates, sometimes the extremes, sometimes any pattern.
   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2, 3: return $urandom();
         default: return $signed(32'($urandom_range(0, 15))) - 8;
      endcase
   endfunction

   // Issue one command word: drop start while idling, then hold the word until
   // accepted. Start stays high afterwards; the next call drops it if it idles, else the end does.
   task automatic send_word(opcode_type op, logic signed [31:0] v, int pos, logic asc);
      while ($urandom_range(0, 99) < idle_percent) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start          <= 1'b1;
      req_opcode     <= op;
      req_item_value <= v;
      req_position   <= 7'(pos);
      req_ascending  <= asc;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      // Word taken at that edge: track the length locally to aim positions.
      case (op)
         OP_CLEAR: list_size = 0;
         OP_INSERT: if (list_size < 64 && pos <= list_size) list_size++;
         OP_APPEND: if (list_size < 64) list_size++;
         OP_DELETE: if (list_size > 0 && pos < list_size) list_size--;
         OP_DELETE_LAST: if (list_size > 0) list_size--;
         default: ;
      endcase
   endtask

   task automatic send_random_word();
      int pos;
      opcode_type op;
      case ($urandom_range(0, 19))
         0: op = OP_CLEAR;
         1, 2, 3, 4: op = OP_INSERT;
         5, 6, 7: op = OP_APPEND;
         8, 9, 10: op = OP_DELETE;
         11, 12: op = OP_DELETE_LAST;
         13, 14, 15: op = OP_FIND;
         16, 17: op = OP_EXTREMES;
         default: op = OP_SORT;
      endcase
      // Mostly in range, sometimes just past the end, rarely anywhere.
      case ($urandom_range(0, 9))
         0: pos = list_size;
         1: pos = $urandom_range(0, 127);
         default: pos = $urandom_range(0, list_size > 0 ? list_size - 1 : 0);
      endcase
      send_word(op, pick_value(), pos, $urandom_range(0, 1));
   endtask

   initial begin
      idle_percent = 0;
      list_size    = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty-list cases first.
      send_word(OP_DELETE, 0, 0, 0);
      send_word(OP_DELETE_LAST, 0, 0, 0);
      send_word(OP_FIND, 0, 0, 0);
      send_word(OP_EXTREMES, 0, 0, 0);
      send_word(OP_SORT, 0, 0, 1);
      send_word(OP_INSERT, 5, 1, 0);            // past the end
      send_word(OP_INSERT, 32'sh7FFF_FFFF, 0, 0);
      send_word(OP_INSERT, 32'sh8000_0000, 1, 1); // position equal to length
      send_word(OP_APPEND, -1, 127, 1);
      send_word(OP_INSERT, 7, 1, 0);
      send_word(OP_FIND, -1, 0, 0);              // match on last element
      send_word(OP_FIND, 3, 0, 0);
      send_word(OP_EXTREMES, 0, 0, 0);
      send_word(OP_SORT, 0, 0, 1);
      send_word(OP_SORT, 0, 0, 0);
      send_word(OP_DELETE, 0, 4, 0);             // past the end
      send_word(OP_DELETE, 0, 127, 0);
      send_word(OP_DELETE, 0, 1, 0);
      send_word(OP_DELETE_LAST, 0, 0, 0);
      // Fill to capacity, then hit the full cases.
      while (list_size < 64) send_word(OP_APPEND, pick_value(), 0, 0);
      send_word(OP_APPEND, 1, 0, 0);
      send_word(OP_INSERT, 1, 0, 0);
      send_word(OP_SORT, 0, 0, 0);
      send_word(OP_FIND, 32'sh7FFF_FFFF, 0, 0);
      send_word(OP_CLEAR, 0, 0, 0);

      // Random phases, each with its own sender idle rate.
      for (int k = 0; k < 4; k++) begin
         idle_percent = (k == 1) ? 56 : (k == 3) ? 34 : 0;
         repeat (130) send_random_word();
      end
      start <= 1'b0;

      while (pending_words != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

   // Watchdog: fail the run if it has not finished in time, sized for sorts of 64.
   initial begin
      #200_000_000;
      $display("tb_top: FAIL");
      $finish;
   end
endmodule
